### src/olpid_pkg.sv
// Package for the ordered list block: sizes, operation and status codes.
// Used by every module under src.
`timescale 1ns / 1ps
package olpid_pkg;
  localparam int Capacity = 64;
  localparam int AddrW    = $clog2(Capacity);
  localparam int CountW   = 7;
  localparam int DataW    = 32;

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_AT   = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Memory port commands from the controller.
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [DataW-1:0] wr_data;
  } mem_cmd_t;
endpackage

### src/olpid_ram.sv
// Single-port-write, single-read synchronous RAM holding the list elements.
// Depends on olpid_pkg for the command struct.
`timescale 1ns / 1ps
module olpid_ram (
  input  logic                                clk_i,
  input  olpid_pkg::mem_cmd_t                 cmd_i,
  output logic [olpid_pkg::DataW-1:0]         rd_data_o
);
  import olpid_pkg::*;

  logic [DataW-1:0] mem_q [Capacity];

  // Write then read, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= cmd_i.wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_o <= mem_q[cmd_i.rd_addr];
    end
  end
endmodule

### src/olpid_ctrl.sv
// Sequencer for list operations: decodes, shifts entries one per step
// through the RAM, builds the result word. Depends on olpid_pkg.
`timescale 1ns / 1ps
module olpid_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    op_i,
  input  logic [olpid_pkg::DataW-1:0]   value_i,
  input  logic [7:0]                    position_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [olpid_pkg::DataW-1:0]   data_out_o,
  output logic [olpid_pkg::CountW-1:0]  count_o,
  output olpid_pkg::mem_cmd_t           cmd_o,
  input  logic [olpid_pkg::DataW-1:0]   rd_data_i
);
  import olpid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_DEL, S_GRAB, S_READ, S_DONE
  } state_e;

  localparam int PosW = AddrW + 2;

  state_e           state_q;
  logic [PosW-1:0]  len_q;      // element count
  logic [PosW-1:0]  k_q;        // walking index
  logic [PosW-1:0]  stop_q;     // target slot
  logic             pend_q;     // read in flight
  logic [DataW-1:0] val_q;
  logic [1:0]       status_q;
  logic [DataW-1:0] data_q;
  logic             out_valid_q;

  logic [PosW-1:0] pos_w;
  logic            pos_ins_ok;
  logic            pos_rd_ok;
  assign pos_w      = PosW'(position_i);
  assign pos_ins_ok = (pos_w >= PosW'(1)) && (pos_w <= len_q + PosW'(1));
  assign pos_rd_ok  = (pos_w >= PosW'(1)) && (pos_w <= len_q);

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign count_o     = CountW'(len_q);

  // Drive memory: insert walks down reading k-1, delete walks up reading k+1
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_INS: begin
        if (k_q > stop_q) begin
          cmd_o.rd_en   = !pend_q;
          cmd_o.rd_addr = AddrW'(k_q - PosW'(1));
          cmd_o.wr_en   = pend_q;
          cmd_o.wr_addr = AddrW'(k_q);
          cmd_o.wr_data = rd_data_i;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = AddrW'(k_q);
          cmd_o.wr_data = val_q;
        end
      end
      S_GRAB, S_READ: begin
        cmd_o.rd_en   = !pend_q;
        cmd_o.rd_addr = AddrW'(stop_q);
      end
      S_DEL: begin
        cmd_o.rd_en   = !pend_q && (k_q + PosW'(1) < len_q);
        cmd_o.rd_addr = AddrW'(k_q + PosW'(1));
        cmd_o.wr_en   = pend_q;
        cmd_o.wr_addr = AddrW'(k_q);
        cmd_o.wr_data = rd_data_i;
      end
      default: cmd_o = '0;
    endcase
  end

  // Hold state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      k_q         <= '0;
      stop_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      data_q      <= '0;
      val_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            status_q <= ST_OK;
            data_q   <= '0;
            val_q    <= value_i;
            pend_q   <= 1'b0;
            case (op_i)
              OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                if (len_q >= PosW'(Capacity)) begin
                  status_q <= ST_FULL; state_q <= S_DONE;
                end else if (op_i == OP_INS_FIRST || len_q == '0) begin
                  stop_q <= '0; k_q <= len_q; state_q <= S_INS;
                end else if (op_i == OP_INS_LAST) begin
                  stop_q <= len_q; k_q <= len_q; state_q <= S_INS;
                end else if (pos_ins_ok) begin
                  stop_q <= pos_w - PosW'(1); k_q <= len_q; state_q <= S_INS;
                end else begin
                  status_q <= ST_BADPOS; state_q <= S_DONE;
                end
              end
              OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT, OP_READ_AT: begin
                if (len_q == '0) begin
                  status_q <= ST_EMPTY; state_q <= S_DONE;
                end else if (op_i == OP_DEL_FIRST) begin
                  stop_q <= '0; state_q <= S_GRAB;
                end else if (op_i == OP_DEL_LAST) begin
                  stop_q <= len_q - PosW'(1); state_q <= S_GRAB;
                end else if (!pos_rd_ok) begin
                  status_q <= ST_BADPOS; state_q <= S_DONE;
                end else begin
                  stop_q  <= pos_w - PosW'(1);
                  state_q <= (op_i == OP_DEL_AT) ? S_GRAB : S_READ;
                end
              end
              default: begin
                status_q <= ST_BADPOS; state_q <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          if (k_q > stop_q) begin
            pend_q <= !pend_q;
            if (pend_q) k_q <= k_q - PosW'(1);
          end else begin
            len_q   <= len_q + PosW'(1);
            state_q <= S_DONE;
          end
        end
        S_GRAB: begin
          // pend_q toggles back to zero on the data cycle
          pend_q <= !pend_q;
          if (pend_q) begin
            data_q  <= rd_data_i;
            k_q     <= stop_q;
            state_q <= S_DEL;
          end
        end
        S_READ: begin
          pend_q <= !pend_q;
          if (pend_q) begin
            data_q  <= rd_data_i;
            state_q <= S_DONE;
          end
        end
        S_DEL: begin
          if (k_q + PosW'(1) < len_q) begin
            pend_q <= !pend_q;
            if (pend_q) k_q <= k_q + PosW'(1);
          end else begin
            len_q   <= len_q - PosW'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Count never exceeds capacity
  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PosW'(Capacity)) else $error("length over capacity");
  // No new word while a result waits
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("accept while result pending");
  // Errors return zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> data_q == '0)
    else $error("error with nonzero data");
endmodule

### src/ordered_list_positional_insert_delete.sv
// Top level of the bounded ordered list; wires the sequencer to the RAM.
// Depends on olpid_pkg, olpid_ctrl and olpid_ram.
`timescale 1ns / 1ps
// Ordered list of up to 64 signed 32-bit values held in one synchronous RAM.
// One word in gives one result word out. An insert or a delete at a slot
// moves every element behind the slot by one read and one write on the
// single RAM port pair. The next word is accepted only once the result word
// has been taken.
module ordered_list_positional_insert_delete (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // op[2:0], value[34:3], position[42:35], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], data_out[33:2], count[40:34], zero
);
  import olpid_pkg::*;

  mem_cmd_t         cmd;
  logic [DataW-1:0] rd_data;
  logic [1:0]       status;
  logic [DataW-1:0] data_out;
  logic [CountW-1:0] count;

  olpid_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tdata[2:0]),
    .value_i    (s_axis_tdata[34:3]),
    .position_i (s_axis_tdata[42:35]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_o   (status),
    .data_out_o (data_out),
    .count_o    (count),
    .cmd_o      (cmd),
    .rd_data_i  (rd_data)
  );

  olpid_ram u_ram (.clk_i, .cmd_i(cmd), .rd_data_o(rd_data));

  assign m_axis_tdata = {7'd0, count, data_out, status};
endmodule

### bench/ordered_list_positional_insert_delete_test.sv
// Self-checking bench for the bounded ordered list block.
// Depends on olpid_pkg and ordered_list_positional_insert_delete.
`timescale 1ns / 1ps
module ordered_list_positional_insert_delete_test;
  import olpid_pkg::*;

  typedef struct packed {
    logic [7:0]  position;
    logic [31:0] value;
    logic [2:0]  op;
  } list_cmd_t;

  typedef struct {
    status_e     status;
    logic [31:0] data_out;
    logic [6:0]  count;
  } list_reply_t;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  list_cmd_t   pending_cmds[$];
  list_reply_t expected_replies[$];
  logic [31:0] shadow_list[$];
  int          error_count = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          idle_cycles = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  bit          stim_done = 1'b0;
  bit          hold_sink = 1'b0;
  bit          saw_op[8];

  ordered_list_positional_insert_delete dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Apply one command to the shadow list and return the expected reply.
  function automatic list_reply_t apply_list_op(list_cmd_t c);
    list_reply_t r;
    int n;
    n = shadow_list.size();
    r.status = ST_OK;
    r.data_out = '0;
    case (op_e'(c.op))
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        if (n >= Capacity) r.status = ST_FULL;
        else if (op_e'(c.op) == OP_INS_FIRST || n == 0) shadow_list.push_front(c.value);
        else if (op_e'(c.op) == OP_INS_LAST) shadow_list.push_back(c.value);
        else if (c.position >= 1 && c.position <= n + 1)
          shadow_list.insert(c.position - 1, c.value);
        else r.status = ST_BADPOS;
      end
      OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT, OP_READ_AT: begin
        if (n == 0) r.status = ST_EMPTY;
        else if (op_e'(c.op) == OP_DEL_FIRST) r.data_out = shadow_list.pop_front();
        else if (op_e'(c.op) == OP_DEL_LAST) r.data_out = shadow_list.pop_back();
        else if (c.position < 1 || c.position > n) r.status = ST_BADPOS;
        else if (op_e'(c.op) == OP_DEL_AT) begin
          r.data_out = shadow_list[c.position - 1];
          shadow_list.delete(c.position - 1);
        end else r.data_out = shadow_list[c.position - 1];
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count = 7'(shadow_list.size());
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(99) < 40) return 0;
    if ($urandom_range(99) < 90) return $urandom_range(3);
    return $urandom_range(40);
  endfunction

  function automatic list_cmd_t make_cmd(logic [2:0] op, logic [31:0] v, logic [7:0] p);
    list_cmd_t c;
    c.op = op;
    c.value = v;
    c.position = p;
    return c;
  endfunction

  // Drive queued words; predict on acceptance.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(apply_list_op(list_cmd_t'(s_axis_tdata[42:0])));
        saw_op[s_axis_tdata[2:0]] = 1'b1;
        words_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          s_axis_tdata <= {5'd0, pending_cmds.pop_front()};
          s_axis_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Accept and check result words.
  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (expected_replies.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tdata[1:0]);
            error_count++;
          end
          if (m_axis_tdata[33:2] !== want.data_out) begin
            $error("data_out: expected %h, actual %h", want.data_out, m_axis_tdata[33:2]);
            error_count++;
          end
          if (m_axis_tdata[40:34] !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, m_axis_tdata[40:34]);
            error_count++;
          end
        end
      end
      if (hold_sink) m_axis_tready <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no word moving either way.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("ordered_list_positional_insert_delete_test: FAIL");
        $finish;
      end
    end
  end

  // Hold the sink off once for a long stretch while the source keeps offering words.
  initial begin
    int k;
    wait (words_in > 300);
    hold_sink = 1'b1;
    for (k = 0; k < 400; k++) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  initial begin
    int i, j, model_len, r;
    logic [2:0] op;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-list errors, odd positions, extremes, unused code.
    pending_cmds.push_back(make_cmd(OP_DEL_FIRST, 32'hFFFFFFFF, 8'd1));
    pending_cmds.push_back(make_cmd(OP_DEL_LAST, 32'd0, 8'd0));
    pending_cmds.push_back(make_cmd(OP_DEL_AT, 32'd0, 8'd1));
    pending_cmds.push_back(make_cmd(OP_READ_AT, 32'd0, 8'd1));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 32'h80000000, 8'd255));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 32'h7FFFFFFF, 8'd0));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 32'd5, 8'd3));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 32'd6, 8'd4));
    pending_cmds.push_back(make_cmd(OP_INS_AT, 32'd7, 8'd1));
    pending_cmds.push_back(make_cmd(OP_INS_LAST, 32'hFFFFFFFF, 8'd0));
    pending_cmds.push_back(make_cmd(OP_INS_FIRST, 32'd1, 8'd0));
    pending_cmds.push_back(make_cmd(OP_READ_AT, 32'd0, 8'd0));
    pending_cmds.push_back(make_cmd(OP_READ_AT, 32'd0, 8'd7));
    pending_cmds.push_back(make_cmd(OP_READ_AT, 32'd0, 8'd6));
    pending_cmds.push_back(make_cmd(OP_DEL_AT, 32'd0, 8'd255));
    pending_cmds.push_back(make_cmd(OP_DEL_AT, 32'd0, 8'd3));
    pending_cmds.push_back(make_cmd(OP_NONE, 32'hFFFFFFFF, 8'hFF));
    pending_cmds.push_back(make_cmd(OP_DEL_LAST, 32'd0, 8'd0));
    pending_cmds.push_back(make_cmd(OP_DEL_FIRST, 32'd0, 8'd0));
    model_len = 1;

    // Random: long phases biased to fill up to full and drain down to empty.
    for (i = 0; i < 800; i++) begin
      r = $urandom_range(99);
      if ((i / 200) % 2 == 0) op = (r < 70) ? 3'($urandom_range(2)) : 3'($urandom_range(6, 3));
      else op = (r < 70) ? 3'($urandom_range(6, 3)) : 3'($urandom_range(2));
      if ($urandom_range(99) < 2) op = OP_NONE;
      if (op <= OP_INS_AT && model_len < Capacity) model_len++;
      else if (op >= OP_DEL_FIRST && op <= OP_DEL_AT && model_len > 0) model_len--;
      j = (model_len < 1) ? 1 : model_len;
      pending_cmds.push_back(make_cmd(op, $urandom(),
          ($urandom_range(99) < 88) ? 8'($urandom_range(j + 1, 1)) : 8'($urandom_range(255))));
    end

    wait (pending_cmds.size() == 0 && !s_axis_tvalid);
    wait (expected_replies.size() == 0);
    repeat (200) @(posedge clk_i);
    if (m_axis_tvalid) begin
      $error("result word left over after the last expected one");
      error_count++;
    end
    $display("%0d command words sent, %0d result words checked; list driven", words_in,
             words_out);
    $display("through empty and full states with every op code, including the unused one");
    if (error_count == 0 && saw_op[7]) $display("ordered_list_positional_insert_delete_test: PASS");
    else $display("ordered_list_positional_insert_delete_test: FAIL");
    $finish;
  end
endmodule
